>>> rtl/ffafe_pkg.sv
// ----------------------------------------------------------------------------
// ffafe_pkg: shared types and constants of the ASCII field extractor
// Field table, keyword codes, character codes and the word that travels
// from the front end to the parser through the queue.
// ----------------------------------------------------------------------------
package ffafe_pkg;

   localparam int NUM_FIELDS = 19;
   localparam int FIELD_W    = 5;
   localparam int POS_W      = 10;
   localparam int MAG_W      = 20;
   localparam int VALUE_W    = 21;
   localparam int PROD_W     = 24;

   localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
   localparam logic [MAG_W-1:0] MAG_MAX = 20'd999999;

   localparam logic [55:0] KEY_MISSING = 56'h4D495353494E47;
   localparam logic [55:0] KEY_DISABLE = 56'h44495341424C45;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [POS_W-1:0] FIELD_START [NUM_FIELDS] = '{
      10'd4,   10'd10,  10'd16,  10'd22,  10'd28,  10'd35,  10'd42,
      10'd231, 10'd238, 10'd245, 10'd252, 10'd259, 10'd266, 10'd273,
      10'd280, 10'd287, 10'd294, 10'd301, 10'd308
   };
   localparam logic [POS_W-1:0] FIELD_LEN [NUM_FIELDS] = '{
      10'd6, 10'd6, 10'd6, 10'd6, 10'd7, 10'd7, 10'd7,
      10'd7, 10'd7, 10'd7, 10'd7, 10'd7, 10'd7, 10'd7,
      10'd7, 10'd7, 10'd7, 10'd7, 10'd7
   };

   // Where a byte falls in the frame.
   typedef struct packed {
      logic               in_field;
      logic [FIELD_W-1:0] field;
      logic               first;
      logic               close;
   } class_type;

   // One classified byte, handed from the front end to the parser.
   typedef struct packed {
      logic [7:0]         ch;
      logic [FIELD_W-1:0] field;
      logic               in_field;
      logic               first;
      logic               close;
      logic               last;
      logic               good;
   } entry_type;

   // The fields do not overlap, so the matches are independent compares.
   function automatic class_type classify(input logic [POS_W-1:0] pos);
      class_type r;
      r = '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
         if (pos >= FIELD_START[i] && pos < FIELD_START[i] + FIELD_LEN[i]) begin
            r.in_field = 1'b1;
            r.field    = FIELD_W'(i);
            r.first    = (pos == FIELD_START[i]);
            r.close    = (pos == FIELD_START[i] + FIELD_LEN[i] - 10'd1);
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/ffafe_front.sv
// ----------------------------------------------------------------------------
// ffafe_front: byte intake and classification
// Tracks the frame position and the last six bytes, flags the MISSING and
// DISABLE keywords and tags each byte with its field and the frame verdict.
// ----------------------------------------------------------------------------
module ffafe_front #(
   parameter int FRAME_LENGTH = 320
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte_in,
   input  logic                 req_end_of_reply,
   output logic                 push_valid,
   input  logic                 push_ready,
   output ffafe_pkg::entry_type push_entry
);
   import ffafe_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [47:0]      recent_ff, recent_in;
   logic             kw_ff, kw_in;
   logic [55:0]      window;
   logic             kw_now;
   logic             accept;
   class_type        cls;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   always_comb begin
      window = {recent_ff, req_byte_in};
      kw_now = kw_ff || (window == KEY_MISSING) || (window == KEY_DISABLE);
      cls    = classify(pos_ff);

      push_entry.ch       = req_byte_in;
      push_entry.field    = cls.field;
      push_entry.in_field = cls.in_field;
      push_entry.first    = cls.first;
      push_entry.close    = cls.close;
      push_entry.last     = req_end_of_reply;
      // A saturated position gives 1024 here and never matches the length.
      push_entry.good     = (({1'b0, pos_ff} + 11'd1) == 11'(FRAME_LENGTH)) && !kw_now;

      pos_in    = pos_ff;
      recent_in = recent_ff;
      kw_in     = kw_ff;
      if (accept) begin
         if (req_end_of_reply) begin
            pos_in    = '0;
            recent_in = '0;
            kw_in     = 1'b0;
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 10'd1;
            end
            recent_in = window[47:0];
            kw_in     = kw_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         recent_ff <= '0;
         kw_ff     <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         recent_ff <= recent_in;
         kw_ff     <= kw_in;
      end
   end

endmodule

>>> rtl/ffafe_queue.sv
// ----------------------------------------------------------------------------
// ffafe_queue: short queue between front end and parser
// A register FIFO of classified byte words.
// ----------------------------------------------------------------------------
module ffafe_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ffafe_pkg::entry_type in_entry,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ffafe_pkg::entry_type out_entry
);
   import ffafe_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   push, pop;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

>>> rtl/ffafe_back.sv
// ----------------------------------------------------------------------------
// ffafe_back: number parser and result register
// Runs the leading-space, sign and digit steps on each classified byte and
// holds one finished result word for the result channel.
// ----------------------------------------------------------------------------
module ffafe_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  ffafe_pkg::entry_type           pop_entry,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_result_kind,
   output logic [ffafe_pkg::FIELD_W-1:0]  rsp_field_number,
   output logic signed [ffafe_pkg::VALUE_W-1:0] rsp_field_value,
   output logic                           rsp_reply_good
);
   import ffafe_pkg::*;

   typedef enum logic [1:0] {
      PH_LEAD   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in, phase_t;
   logic [MAG_W-1:0]   mag_ff, mag_in, mag_t;
   logic               neg_ff, neg_in, neg_t;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [FIELD_W-1:0] fnum_ff, fnum_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               good_ff, good_in;
   logic [PROD_W-1:0]  prod;
   logic [VALUE_W-1:0] mag_ext;
   logic [7:0]         c;
   logic               is_space, is_digit, makes_result, consume;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_field_number = fnum_ff;
   assign rsp_field_value  = value_ff;
   assign rsp_reply_good   = good_ff;

   always_comb begin
      c        = pop_entry.ch;
      is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

      // A field restarts the parse at its first byte.
      mag_t   = pop_entry.first ? '0 : mag_ff;
      neg_t   = pop_entry.first ? 1'b0 : neg_ff;
      phase_t = pop_entry.first ? PH_LEAD : phase_ff;
      prod    = {mag_t, 3'b000} + {2'b00, mag_t, 1'b0} + PROD_W'(c - CHAR_ZERO);

      if (pop_entry.in_field) begin
         if (phase_t == PH_LEAD && is_space) begin
            phase_t = PH_LEAD;
         end else if (phase_t == PH_LEAD && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
            neg_t   = (c == CHAR_MINUS);
            phase_t = PH_SIGN;
         end else if (phase_t != PH_DONE) begin
            if (is_digit) begin
               mag_t   = (prod > PROD_W'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
               phase_t = PH_DIGITS;
            end else begin
               phase_t = PH_DONE;
            end
         end
      end

      mag_ext      = {1'b0, mag_t};
      makes_result = pop_entry.last || (pop_entry.in_field && pop_entry.close);
      consume      = pop_valid && (!makes_result || !rsp_valid_ff || rsp_ready);
      pop_ready    = !makes_result || !rsp_valid_ff || rsp_ready;

      phase_in     = phase_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      fnum_in      = fnum_ff;
      value_in     = value_ff;
      good_in      = good_ff;

      if (consume) begin
         if (pop_entry.last) begin
            phase_in     = PH_LEAD;
            mag_in       = '0;
            neg_in       = 1'b0;
            rsp_valid_in = 1'b1;
            kind_in      = 1'b1;
            fnum_in      = '0;
            value_in     = '0;
            good_in      = pop_entry.good;
         end else begin
            phase_in = phase_t;
            mag_in   = mag_t;
            neg_in   = neg_t;
            if (makes_result) begin
               rsp_valid_in = 1'b1;
               kind_in      = 1'b0;
               fnum_in      = pop_entry.field;
               value_in     = neg_t ? (~mag_ext + 1'b1) : mag_ext;
               good_in      = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      fnum_ff  <= fnum_in;
      value_ff <= value_in;
      good_ff  <= good_in;
   end

endmodule

>>> rtl/fixed_frame_ascii_field_extractor_unit.sv
// ----------------------------------------------------------------------------
// fixed_frame_ascii_field_extractor_unit: ASCII tracker reply field extractor
// Parses nineteen fixed-offset decimal fields from a reply byte stream and
// reports a frame verdict at the last byte of each reply.
// ----------------------------------------------------------------------------
// The block takes one reply byte per word on the req_ channel and accepts a
// new word in every clock cycle, so a reply streams in at one byte per cycle
// for as long as the result side keeps up. A front end tags each byte with
// its frame position, its field and the running keyword check; a four-word
// queue then feeds the parser, which turns each field into a signed integer
// the way atoi does and holds the result in an output register. A byte that
// closes a field is written into the queue and, once the result register
// is free, the parser turns it into a result word that the result register
// drives onto rsp_.
// Only bytes that close a field or end a reply make results, so a stalled
// rsp_ side backs up into the queue and then into req_ready; other bytes keep
// flowing. Field results carry field_number 0 to 3 (quaternion, in
// ten-thousandths), 4 to 6 (probe x, y, z, in hundredths) and 7 to 18 (rigid
// marker coordinates, in hundredths); the value is not scaled. The verdict
// word (result_kind 1) reports reply_good when the reply held exactly
// FRAME_LENGTH bytes and neither MISSING nor DISABLE appeared in it. A field
// cut off by the end of the reply is dropped, and a byte position that runs
// past 1023 saturates there.
// ----------------------------------------------------------------------------
module fixed_frame_ascii_field_extractor_unit #(
   parameter int FRAME_LENGTH = 320
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_byte_in,
   input  logic                                 req_end_of_reply,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_result_kind,
   output logic [ffafe_pkg::FIELD_W-1:0]        rsp_field_number,
   output logic signed [ffafe_pkg::VALUE_W-1:0] rsp_field_value,
   output logic                                 rsp_reply_good
);
   import ffafe_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   // Front end: position, keyword window and field tagging.
   ffafe_front #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_end_of_reply (req_end_of_reply),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   // Decoupling queue so each side can stall on its own.
   ffafe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   // Parser and result register.
   ffafe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_field_number (rsp_field_number),
      .rsp_field_value  (rsp_field_value),
      .rsp_reply_good   (rsp_reply_good)
   );

endmodule

>>> sim/fixed_frame_ascii_field_extractor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_frame_ascii_field_extractor_unit_tb: reply parser testbench
// Streams tracker replies into the extractor one byte per word and checks
// every field value and frame verdict against a cycle-free model of the
// parser, under random stalls on both channels.
// ----------------------------------------------------------------------------
module fixed_frame_ascii_field_extractor_unit_tb;

   import ffafe_pkg::*;

   localparam int FRAME_LEN     = 320;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic KIND_FIELD   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Characters that stress the number parser when mixed into a field.
   localparam logic [7:0] MIXED_CHARS [10] = '{
      CHAR_ZERO, CHAR_NINE, 8'h35, CHAR_PLUS, CHAR_MINUS,
      CHAR_SPACE, CHAR_TAB, 8'h2E, 8'h00, 8'hFF
   };

   // Where the number parser stands inside the current field.
   typedef enum logic [1:0] {
      PARSE_LEAD, PARSE_SIGN, PARSE_DIGITS, PARSE_DONE
   } parse_phase_type;

   // How the content of one field is made up when a reply is built.
   typedef enum int {
      FILL_NUMBER, FILL_EXTREME, FILL_OVERFLOW, FILL_PADDED, FILL_MIXED, FILL_RANDOM
   } fill_style_type;

   // One result word as the extractor should deliver it.
   typedef struct packed {
      logic               kind;
      logic [FIELD_W-1:0] field;
      logic [VALUE_W-1:0] value;
      logic               good;
   } result_word_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_byte_in      = 8'h00;
   logic                      req_end_of_reply = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic                      rsp_result_kind;
   logic [FIELD_W-1:0]        rsp_field_number;
   logic signed [VALUE_W-1:0] rsp_field_value;
   logic                      rsp_reply_good;

   // Parser state as the extractor should hold it.
   logic [POS_W-1:0] frame_pos      = '0;
   logic [47:0]      tail_chars     = '0;
   logic             keyword_hit    = 1'b0;
   logic [MAG_W-1:0] number_mag     = '0;
   logic             number_neg     = 1'b0;
   parse_phase_type  number_phase   = PARSE_LEAD;

   result_word_type  pending_results [$];
   logic [7:0]       reply_buf [$];

   int send_idle_pct    = 38;
   int recv_idle_pct    = 76;
   int mismatches       = 0;
   int bytes_sent       = 0;
   int replies_sent     = 0;
   int fields_checked   = 0;
   int verdicts_checked = 0;
   int good_frames      = 0;
   int quiet_cycles     = 0;

   fixed_frame_ascii_field_extractor_unit #(
      .FRAME_LENGTH(FRAME_LEN)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .req_end_of_reply (req_end_of_reply),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_field_number (rsp_field_number),
      .rsp_field_value  (rsp_field_value),
      .rsp_reply_good   (rsp_reply_good)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Number parser: one character of the current field, atoi style. White
   // space is skipped before the number, one sign may follow, and digits are
   // taken until the first character that is not a digit. The magnitude
   // clips at 999999.
   // ------------------------------------------------------------------------
   function automatic void advance_number(input logic [7:0] ch);
      bit digit;
      int v;
      digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      if (number_phase == PARSE_LEAD) begin
         if (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR))
            return;
         if (ch == CHAR_MINUS || ch == CHAR_PLUS) begin
            number_neg   = (ch == CHAR_MINUS);
            number_phase = PARSE_SIGN;
            return;
         end
      end
      if (number_phase == PARSE_DONE)
         return;
      if (digit) begin
         v = int'(number_mag) * 10 + int'(ch) - int'(CHAR_ZERO);
         number_mag   = (v > int'(MAG_MAX)) ? MAG_MAX : MAG_W'(v);
         number_phase = PARSE_DIGITS;
      end else begin
         number_phase = PARSE_DONE;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Frame tracker: takes one accepted byte and queues the result word it
   // should cause, if any. The keyword window sees every byte; fields are
   // located by position, and the position sticks at its maximum so that an
   // overlong reply never matches the frame length. The end byte wins over a
   // field that would close on the same byte, and wipes all parser state.
   // ------------------------------------------------------------------------
   function automatic void parse_reply_byte(input logic [7:0] ch, input logic last);
      logic [55:0]     window;
      int              at;
      int              field_idx;
      int              s;
      int              l;
      bit              closes;
      result_word_type w;
      window = {tail_chars, ch};
      if (window == KEY_MISSING || window == KEY_DISABLE)
         keyword_hit = 1'b1;
      tail_chars = window[47:0];
      at         = int'(frame_pos);
      field_idx  = -1;
      closes     = 1'b0;
      if (at < int'(POS_MAX)) begin
         for (int i = 0; i < NUM_FIELDS; i++) begin
            s = int'(FIELD_START[i]);
            l = int'(FIELD_LEN[i]);
            if (field_idx < 0 && at >= s && at < s + l)
               field_idx = i;
         end
      end
      if (field_idx >= 0) begin
         s = int'(FIELD_START[field_idx]);
         l = int'(FIELD_LEN[field_idx]);
         if (at == s) begin
            number_mag   = '0;
            number_neg   = 1'b0;
            number_phase = PARSE_LEAD;
         end
         advance_number(ch);
         closes = (at == s + l - 1);
      end
      if (frame_pos < POS_MAX)
         frame_pos = frame_pos + 1'b1;
      w = '0;
      if (last) begin
         w.kind = KIND_VERDICT;
         w.good = (at + 1 == FRAME_LEN) && !keyword_hit;
         pending_results.push_back(w);
         frame_pos    = '0;
         tail_chars   = '0;
         keyword_hit  = 1'b0;
         number_mag   = '0;
         number_neg   = 1'b0;
         number_phase = PARSE_LEAD;
      end else if (closes) begin
         w.kind  = KIND_FIELD;
         w.field = FIELD_W'(field_idx);
         w.value = number_neg ? -{1'b0, number_mag} : {1'b0, number_mag};
         pending_results.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Sender. Every call starts and ends at a rising edge. Valid is only
   // lowered when the sender actually idles, so a word that follows right
   // after the previous one keeps valid high without a glitch.
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] ch, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_byte_in      <= ch;
      req_end_of_reply <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      parse_reply_byte(ch, last);
      bytes_sent++;
      if (last)
         replies_sent++;
   endtask

   // Stops sending and waits until every queued result has been delivered.
   // The loop waits on the clock before it checks, so valid is never dropped and raised again
   // within the same step.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_results.size() != 0);
   endtask

   task automatic send_text(input string text, input bit close_reply);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], close_reply && (i == text.len() - 1));
   endtask

   // Sends the reply held in reply_buf; the end mark rides on its last byte.
   // Now and then the sender waits mid-reply for the result side to empty.
   task automatic send_reply();
      for (int i = 0; i < reply_buf.size(); i++) begin
         if ($urandom_range(499) == 0)
            hold_until_drained();
         send_byte(reply_buf[i], i == reply_buf.size() - 1);
      end
   endtask

   task automatic plant_text(input int at, input string text);
      for (int i = 0; i < text.len(); i++)
         if (at + i < reply_buf.size())
            reply_buf[at + i] = text[i];
   endtask

   // Writes the content of one numeric field into the reply, clipped to the
   // reply length so that short replies end inside their fields.
   task automatic fill_field(input int at, input int width);
      logic [7:0]     text_bytes [7];
      fill_style_type style;
      int             pick;
      int             lead;
      pick  = $urandom_range(99);
      style = (pick < 40) ? FILL_NUMBER :
              (pick < 52) ? FILL_EXTREME :
              (pick < 62) ? FILL_OVERFLOW :
              (pick < 77) ? FILL_PADDED :
              (pick < 90) ? FILL_MIXED : FILL_RANDOM;
      for (int k = 0; k < 7; k++)
         text_bytes[k] = 8'(CHAR_ZERO + $urandom_range(9));
      case (style)
         FILL_NUMBER: begin
            pick = $urandom_range(3);
            if (pick == 0)
               text_bytes[0] = CHAR_PLUS;
            else if (pick == 1)
               text_bytes[0] = CHAR_MINUS;
            else if (pick == 2)
               text_bytes[0] = CHAR_SPACE;
         end
         FILL_EXTREME: begin
            // Largest or smallest magnitude the field can spell with a sign.
            text_bytes[0] = $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS;
            pick = $urandom_range(1);
            for (int k = 1; k < 7; k++)
               text_bytes[k] = pick ? CHAR_NINE : CHAR_ZERO;
         end
         FILL_OVERFLOW: begin
            // Unsigned digits across the whole field; seven of them can
            // exceed the magnitude limit.
            text_bytes[0] = 8'(CHAR_ZERO + $urandom_range(1, 9));
            if ($urandom_range(1))
               for (int k = 0; k < 7; k++)
                  text_bytes[k] = CHAR_NINE;
         end
         FILL_PADDED: begin
            lead = $urandom_range(1, width - 2);
            for (int k = 0; k < lead; k++) begin
               pick = $urandom_range(5);
               text_bytes[k] = (pick == 5) ? CHAR_SPACE : 8'(CHAR_TAB + pick);
            end
            pick = $urandom_range(2);
            if (pick == 0)
               text_bytes[lead] = CHAR_PLUS;
            else if (pick == 1)
               text_bytes[lead] = CHAR_MINUS;
         end
         FILL_MIXED: begin
            for (int k = 0; k < 7; k++)
               text_bytes[k] = MIXED_CHARS[$urandom_range(9)];
         end
         default: begin
            for (int k = 0; k < 7; k++)
               text_bytes[k] = 8'($urandom_range(255));
         end
      endcase
      for (int k = 0; k < width; k++)
         if (at + k < reply_buf.size())
            reply_buf[at + k] = text_bytes[k];
   endtask

   // Builds a reply of the given length: printable filler, all nineteen
   // fields filled, and in a noisy reply some raw bytes and now and then a
   // keyword at a random place.
   task automatic build_reply(input int len, input bit noisy);
      int kw_at;
      reply_buf.delete();
      for (int p = 0; p < len; p++) begin
         if (noisy && $urandom_range(9) == 0)
            reply_buf.push_back(8'($urandom_range(255)));
         else
            reply_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      for (int i = 0; i < NUM_FIELDS; i++)
         fill_field(int'(FIELD_START[i]), int'(FIELD_LEN[i]));
      if (noisy && len >= 7 && $urandom_range(7) == 0) begin
         kw_at = $urandom_range(len - 7);
         if ($urandom_range(1))
            plant_text(kw_at, "MISSING");
         else
            plant_text(kw_at, "DISABLE");
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Hand-made short replies. The first one exercises a sign followed by a
   // blank (no digits, so zero), a tab before a negative number with leading
   // zeros, the most negative six-character value, five white-space codes
   // ahead of a digit, and a NUL end byte on the first byte of a probe field,
   // which must drop that field. The second reply is just the keyword.
   task automatic test_directed_fields();
      send_text("abcd", 1'b0);
      send_text("+ 12  ", 1'b0);
      send_text("\t-0042", 1'b0);
      send_text("-99999", 1'b0);
      send_byte(8'h0B, 1'b0);
      send_byte(8'h0C, 1'b0);
      send_byte(CHAR_CR, 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
      send_byte(CHAR_TAB, 1'b0);
      send_text("5", 1'b0);
      send_byte(8'h00, 1'b1);
      send_text("MISSING", 1'b1);
   endtask

   // A reply long enough to pin the position counter at its maximum and to
   // run past the first field once more if the counter wrapped; the verdict
   // must be bad and the next reply must start from a clean state.
   task automatic test_long_reply();
      build_reply(1034 + $urandom_range(6), 1'b1);
      send_reply();
   endtask

   // Full-length frames: one clean, one with a keyword picked at random and
   // planted in the gap between the probe and the rigid-marker fields.
   task automatic test_frame_verdicts();
      build_reply(FRAME_LEN, 1'b0);
      send_reply();
      build_reply(FRAME_LEN, 1'b0);
      if ($urandom_range(1))
         plant_text($urandom_range(49, 224), "MISSING");
      else
         plant_text($urandom_range(49, 224), "DISABLE");
      send_reply();
   endtask

   // Random replies, mostly of the frame length so that the rigid fields are
   // reached, plus off-by-one lengths and short replies that end inside the
   // early fields. The phase ends with the sender waiting for all results.
   task automatic test_random_replies(input int byte_budget);
      int stop_at;
      int pick;
      int len;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60)
            len = FRAME_LEN;
         else if (pick < 70)
            len = FRAME_LEN - 1 + 2 * $urandom_range(1);
         else if (pick < 90)
            len = $urandom_range(1, 60);
         else
            len = $urandom_range(1, 400);
         build_reply(len, $urandom_range(3) == 0);
         send_reply();
      end
      hold_until_drained();
   endtask

   // ------------------------------------------------------------------------
   // Result checker. Every word taken on rsp_ is matched against the oldest
   // expected word, field by field. The ready for the next edge is drawn
   // after the check, so the check always sees the ready of this edge.
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      result_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result word with none expected, kind %0d field %0d value %0d",
                     $time, rsp_result_kind, rsp_field_number, rsp_field_value);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", want.kind, rsp_result_kind);
            check_field("field_number", want.field, rsp_field_number);
            check_field("field_value", $signed(want.value), rsp_field_value);
            check_field("reply_good", want.good, rsp_reply_good);
            if (want.kind == KIND_VERDICT) begin
               verdicts_checked++;
               if (want.good)
                  good_frames++;
            end else begin
               fields_checked++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a long run of edges with no word moving on either channel
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, pending_results.size());
         $display("fixed_frame_ascii_field_extractor_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence. The stall pattern changes between the phases: slow
   // sender with a slower receiver for the directed and overlong replies,
   // then the reverse for the full frames, then full speed for random ones.
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_fields();
      test_long_reply();
      send_idle_pct = 76;
      recv_idle_pct = 38;
      test_frame_verdicts();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_replies(100);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d reply bytes in %0d replies: short, cut-off, overlong, keyword-tainted",
               bytes_sent, replies_sent);
      $display("and full frames; checked %0d field values and %0d verdicts (%0d good).",
               fields_checked, verdicts_checked, good_frames);
      if (mismatches == 0)
         $display("fixed_frame_ascii_field_extractor_unit test passed");
      else
         $display("fixed_frame_ascii_field_extractor_unit test failed");
      $finish;
   end

endmodule
